### rtl/bae_pkg.sv
// ----------------------------------------------------------------------------
// bae_pkg
// Shared types, constants and command codes of the binary arithmetic encoder.
// ----------------------------------------------------------------------------
package bae_pkg;

  localparam int REG_BITS    = 16;
  localparam int FLUSH_BITS  = 32;
  localparam int MAX_RESULTS = 32;
  localparam int PROB_BITS   = 16;
  localparam int PEND_BITS   = 16;
  localparam int QDEPTH      = 2;

  localparam int FLUSH_EVENTS = (FLUSH_BITS - 1 < MAX_RESULTS) ? FLUSH_BITS - 1 : MAX_RESULTS;
  localparam int FCNT_BITS    = $clog2(FLUSH_EVENTS + 1);
  localparam int QPTR_BITS    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_BITS    = $clog2(QDEPTH + 1);

  typedef logic [REG_BITS-1:0]           word_t;
  typedef logic [REG_BITS:0]             word_x_t;
  typedef logic [REG_BITS+PROB_BITS-1:0] prod_t;
  typedef logic [FLUSH_BITS-1:0]         flush_word_t;
  typedef logic [FCNT_BITS-1:0]          fcnt_t;
  typedef logic [PROB_BITS-1:0]          prob_t;
  typedef logic [PEND_BITS-1:0]          pend_t;
  typedef logic [1:0]                    cmd_code_t;
  typedef logic [QPTR_BITS-1:0]          qptr_t;
  typedef logic [QCNT_BITS-1:0]          qcnt_t;

  localparam word_t HALF       = word_t'(1) << (REG_BITS - 1);
  localparam word_t QUARTER    = word_t'(1) << (REG_BITS - 2);
  localparam word_t RANGE_INIT = HALF - word_t'(1);

  localparam logic [PROB_BITS:0] PROB_ONE  = (PROB_BITS + 1)'(1) << PROB_BITS;
  localparam prob_t              PROB_HALF = prob_t'(1) << (PROB_BITS - 1);
  localparam pend_t              PEND_MAX  = '1;
  localparam fcnt_t              FLUSH_END = fcnt_t'(FLUSH_EVENTS);
  localparam qcnt_t              QFULL     = qcnt_t'(QDEPTH);
  localparam qptr_t              QLAST     = qptr_t'(QDEPTH - 1);

  localparam cmd_code_t CMD_ENCODE  = 2'd0;
  localparam cmd_code_t CMD_FLUSH   = 2'd1;
  localparam cmd_code_t CMD_RESTART = 2'd2;

  typedef enum logic [1:0] {
    OP_ENCODE,
    OP_FLUSH,
    OP_RESTART,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t   op;
    prob_t plps;
    logic  hit_lps;
  } job_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_NARROW,
    S_RENORM,
    S_FLUSH,
    S_LAST
  } state_t;

endpackage

### rtl/bae_in_if.sv
// ----------------------------------------------------------------------------
// bae_in_if
// Command channel of the encoder: valid/ready with one command per transfer.
// ----------------------------------------------------------------------------
interface bae_in_if;
  logic                  valid;
  logic                  ready;
  bae_pkg::cmd_code_t    cmd;
  bae_pkg::prob_t        zero_prob;
  logic                  symbol;

  modport source (output valid, output cmd, output zero_prob, output symbol, input ready);
  modport sink   (input valid, input cmd, input zero_prob, input symbol, output ready);
endinterface

### rtl/bae_out_if.sv
// ----------------------------------------------------------------------------
// bae_out_if
// Result channel of the encoder: one follow event per transfer.
// ----------------------------------------------------------------------------
interface bae_out_if;
  logic           valid;
  logic           ready;
  logic           lead_bit;
  logic           lead_valid;
  bae_pkg::pend_t pending_count;
  logic           last;

  modport source (output valid, output lead_bit, output lead_valid, output pending_count,
                  output last, input ready);
  modport sink   (input valid, input lead_bit, input lead_valid, input pending_count,
                  input last, output ready);
endinterface

### rtl/bae_front.sv
// ----------------------------------------------------------------------------
// bae_front
// Accepts commands, classifies them (operation, LPS probability, LPS hit)
// and buffers them in a short queue toward the coding engine.
// ----------------------------------------------------------------------------
module bae_front (
  input  logic              clk,
  input  logic              rst_n,
  bae_in_if.sink            in_if,
  output logic              q_valid,
  input  logic              q_ready,
  output bae_pkg::job_t     q_data
);

  bae_pkg::job_t q_mem [bae_pkg::QDEPTH];
  bae_pkg::qptr_t wr_ptr_r, rd_ptr_r;
  bae_pkg::qcnt_t cnt_r;
  bae_pkg::job_t  job;
  logic           lps;
  logic           push, pop;

  always_comb begin
    lps         = in_if.zero_prob > bae_pkg::PROB_HALF;
    job.hit_lps = in_if.symbol == lps;
    job.plps    = lps ? bae_pkg::prob_t'(bae_pkg::PROB_ONE - {1'b0, in_if.zero_prob})
                      : in_if.zero_prob;
    unique case (in_if.cmd)
      bae_pkg::CMD_ENCODE:  job.op = bae_pkg::OP_ENCODE;
      bae_pkg::CMD_FLUSH:   job.op = bae_pkg::OP_FLUSH;
      bae_pkg::CMD_RESTART: job.op = bae_pkg::OP_RESTART;
      default:              job.op = bae_pkg::OP_NONE;
    endcase
  end

  assign in_if.ready = cnt_r != bae_pkg::QFULL;
  assign q_valid     = cnt_r != '0;
  assign q_data      = q_mem[rd_ptr_r];
  assign push        = in_if.valid && in_if.ready;
  assign pop         = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == bae_pkg::QLAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == bae_pkg::QLAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### rtl/bae_core.sv
// ----------------------------------------------------------------------------
// bae_core
// Coding engine: interval narrowing, one renormalization step per cycle unless
// stalled, flush bit walk, follow event holding and result output register.
// ----------------------------------------------------------------------------
module bae_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  bae_pkg::job_t q_data,
  bae_out_if.source     out_if
);

  bae_pkg::state_t      state_r, state_nxt;
  bae_pkg::word_t       lo_r, lo_nxt;
  bae_pkg::word_t       range_r, range_nxt;
  bae_pkg::pend_t       pend_r, pend_nxt;
  logic                 first_r, first_nxt;
  bae_pkg::prob_t       plps_r, plps_nxt;
  logic                 hit_r, hit_nxt;
  bae_pkg::prod_t       prod_r, prod_nxt;
  bae_pkg::flush_word_t flush_sr_r, flush_sr_nxt;
  bae_pkg::fcnt_t       fcnt_r, fcnt_nxt;

  logic                 hold_v_r, hold_v_nxt;
  logic                 hold_bit_r, hold_bit_nxt;
  logic                 hold_lv_r, hold_lv_nxt;
  bae_pkg::pend_t       hold_pend_r, hold_pend_nxt;

  logic                 out_valid_r;
  logic                 out_bit_r, out_lv_r, out_last_r;
  bae_pkg::pend_t       out_pend_r;

  logic                 out_free, can_emit;
  logic                 emit_req, emit_bit;
  logic                 push, push_last;
  bae_pkg::word_t       rlps_raw, rlps_c, rlps, r_tmp, lo_tmp;
  bae_pkg::word_x_t     lo_sum;

  assign out_free = !out_valid_r || out_if.ready;
  assign can_emit = !hold_v_r || out_free;
  assign lo_sum   = bae_pkg::word_x_t'(lo_r) + bae_pkg::word_x_t'(range_r);
  assign rlps_raw = bae_pkg::word_t'(prod_r >> bae_pkg::PROB_BITS);
  assign rlps_c   = (rlps_raw == '0) ? bae_pkg::word_t'(1) : rlps_raw;
  assign rlps     = (rlps_c > range_r) ? range_r : rlps_c;

  always_comb begin
    state_nxt    = state_r;
    lo_nxt       = lo_r;
    range_nxt    = range_r;
    pend_nxt     = pend_r;
    first_nxt    = first_r;
    plps_nxt     = plps_r;
    hit_nxt      = hit_r;
    prod_nxt     = prod_r;
    flush_sr_nxt = flush_sr_r;
    fcnt_nxt     = fcnt_r;
    hold_v_nxt   = hold_v_r;
    hold_bit_nxt = hold_bit_r;
    hold_lv_nxt  = hold_lv_r;
    hold_pend_nxt = hold_pend_r;
    q_ready      = 1'b0;
    emit_req     = 1'b0;
    emit_bit     = 1'b0;
    push         = 1'b0;
    push_last    = 1'b0;
    r_tmp        = range_r;
    lo_tmp       = lo_r;

    unique case (state_r)
      bae_pkg::S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          case (q_data.op)
            bae_pkg::OP_ENCODE: begin
              plps_nxt  = q_data.plps;
              hit_nxt   = q_data.hit_lps;
              state_nxt = bae_pkg::S_MUL;
            end
            bae_pkg::OP_FLUSH: begin
              flush_sr_nxt = bae_pkg::flush_word_t'(bae_pkg::word_x_t'(lo_r)
                             + bae_pkg::word_x_t'(range_r >> 1));
              fcnt_nxt     = '0;
              state_nxt    = bae_pkg::S_FLUSH;
            end
            bae_pkg::OP_RESTART: begin
              lo_nxt    = '0;
              range_nxt = bae_pkg::RANGE_INIT;
              pend_nxt  = '0;
              first_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      bae_pkg::S_MUL: begin
        prod_nxt  = bae_pkg::prod_t'(range_r) * bae_pkg::prod_t'(plps_r);
        state_nxt = bae_pkg::S_NARROW;
      end
      bae_pkg::S_NARROW: begin
        if (hit_r) begin
          lo_nxt = lo_r + (range_r - rlps);
          r_tmp  = rlps;
        end else begin
          r_tmp  = range_r - rlps;
        end
        range_nxt = (r_tmp == '0) ? bae_pkg::word_t'(1) : r_tmp;
        state_nxt = bae_pkg::S_RENORM;
      end
      bae_pkg::S_RENORM: begin
        if (range_r >= bae_pkg::QUARTER) begin
          state_nxt = bae_pkg::S_LAST;
        end else if (lo_r >= bae_pkg::HALF) begin
          if (can_emit) begin
            emit_req  = 1'b1;
            emit_bit  = 1'b1;
            lo_tmp    = lo_r - bae_pkg::HALF;
            lo_nxt    = lo_tmp << 1;
            range_nxt = range_r << 1;
          end
        end else if (lo_sum <= bae_pkg::word_x_t'(bae_pkg::HALF)) begin
          if (can_emit) begin
            emit_req  = 1'b1;
            lo_nxt    = lo_r << 1;
            range_nxt = range_r << 1;
          end
        end else begin
          if (pend_r != bae_pkg::PEND_MAX) begin
            pend_nxt = pend_r + 1'b1;
          end
          lo_tmp    = (lo_r >= bae_pkg::QUARTER) ? lo_r - bae_pkg::QUARTER : '0;
          lo_nxt    = lo_tmp << 1;
          range_nxt = range_r << 1;
        end
      end
      bae_pkg::S_FLUSH: begin
        if (fcnt_r == bae_pkg::FLUSH_END) begin
          state_nxt = bae_pkg::S_LAST;
        end else if (can_emit) begin
          emit_req     = 1'b1;
          emit_bit     = flush_sr_r[bae_pkg::FLUSH_BITS-1];
          flush_sr_nxt = flush_sr_r << 1;
          fcnt_nxt     = fcnt_r + 1'b1;
        end
      end
      bae_pkg::S_LAST: begin
        if (!hold_v_r) begin
          state_nxt = bae_pkg::S_IDLE;
        end else if (out_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          hold_v_nxt = 1'b0;
          state_nxt  = bae_pkg::S_IDLE;
        end
      end
      default: state_nxt = bae_pkg::S_IDLE;
    endcase

    if (emit_req) begin
      push          = hold_v_r;
      hold_v_nxt    = 1'b1;
      hold_bit_nxt  = emit_bit;
      hold_lv_nxt   = !first_r;
      hold_pend_nxt = pend_r;
      first_nxt     = 1'b0;
      pend_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bae_pkg::S_IDLE;
      lo_r        <= '0;
      range_r     <= bae_pkg::RANGE_INIT;
      pend_r      <= '0;
      first_r     <= 1'b1;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      lo_r     <= lo_nxt;
      range_r  <= range_nxt;
      pend_r   <= pend_nxt;
      first_r  <= first_nxt;
      hold_v_r <= hold_v_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    plps_r      <= plps_nxt;
    hit_r       <= hit_nxt;
    prod_r      <= prod_nxt;
    flush_sr_r  <= flush_sr_nxt;
    fcnt_r      <= fcnt_nxt;
    hold_bit_r  <= hold_bit_nxt;
    hold_lv_r   <= hold_lv_nxt;
    hold_pend_r <= hold_pend_nxt;
    if (push) begin
      out_bit_r  <= hold_bit_r;
      out_lv_r   <= hold_lv_r;
      out_pend_r <= hold_pend_r;
      out_last_r <= push_last;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.lead_bit      = out_bit_r;
  assign out_if.lead_valid    = out_lv_r;
  assign out_if.pending_count = out_pend_r;
  assign out_if.last          = out_last_r;

  a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bae_pkg::S_IDLE) |-> !hold_v_r)
    else $error("held event left over in idle");

  a_idle_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bae_pkg::S_IDLE) |-> (range_r >= bae_pkg::QUARTER))
    else $error("range not normalized in idle");

  a_renorm_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bae_pkg::S_RENORM) |-> (range_r != '0))
    else $error("zero range during renormalization");

  a_idle_out_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bae_pkg::S_IDLE && out_valid_r) |-> out_last_r)
    else $error("non-final result pending while idle");

endmodule

### rtl/binary_arithmetic_encoder.sv
// Encode steps through the multiply, narrow, renormalize and last states after a queue pop;
// flush walks out 31 events one per cycle unless stalled, then checks the end and pushes.
// The engine takes one command at a time in idle; restart and unused commands stay in idle.
// A 2-entry command queue feeds the engine, which stalls while hold slot and output are full.
// Reset (rst_n low, synchronous) empties the queue and output and restores the interval.
// ----------------------------------------------------------------------------
// binary_arithmetic_encoder
// Binary arithmetic encoder with bit-plus-follow events: command front end,
// queue and coding engine.
// ----------------------------------------------------------------------------
module binary_arithmetic_encoder (
  input  logic      clk,
  input  logic      rst_n,
  bae_in_if.sink    in_if,
  bae_out_if.source out_if
);

  logic          q_valid;
  logic          q_ready;
  bae_pkg::job_t q_data;

  bae_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data)
  );

  bae_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data),
    .out_if  (out_if)
  );

endmodule
